@@ rtl/ecfr_pkg.sv @@
`default_nettype none

package ecfr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int COUNT_W    = 7;

    localparam logic [1:0] KIND_ACCESS  = 2'd0;
    localparam logic [1:0] KIND_FAULT   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_ACCESS  = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_CLR_REF = 3'd3;
    localparam logic [2:0] OP_TAKE    = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FRAME_W-1:0] frame_index;
        logic               is_write;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               needs_writeback;
        logic               was_free;
        logic               found;
    } t_result;

    typedef struct packed {
        logic [2:0]         op;
        logic [FRAME_W-1:0] idx;
        logic               wr;
    } t_tbl_cmd;

    typedef struct packed {
        logic occ;
        logic ref_b;
        logic dirty;
    } t_tbl_rd;

endpackage

`default_nettype wire

@@ rtl/ecfr_frame_table.sv @@
`default_nettype none

module ecfr_frame_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ecfr_pkg::t_tbl_cmd            i_cmd,
    input  wire logic [ecfr_pkg::FRAME_W-1:0]  i_rd_idx,
    output ecfr_pkg::t_tbl_rd                  o_rd
);

    logic [ecfr_pkg::NUM_FRAMES-1:0] r_occ;
    logic [ecfr_pkg::NUM_FRAMES-1:0] r_ref;
    logic [ecfr_pkg::NUM_FRAMES-1:0] r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_ref   <= '0;
            r_dirty <= '0;
        end else begin
            unique case (i_cmd.op)
                ecfr_pkg::OP_ACCESS: begin
                    r_ref[i_cmd.idx] <= 1'b1;
                    if (i_cmd.wr) begin
                        r_dirty[i_cmd.idx] <= 1'b1;
                    end
                end
                ecfr_pkg::OP_RELEASE: begin
                    r_occ[i_cmd.idx] <= 1'b0;
                end
                ecfr_pkg::OP_CLR_REF: begin
                    r_ref[i_cmd.idx] <= 1'b0;
                end
                ecfr_pkg::OP_TAKE: begin
                    r_occ[i_cmd.idx]   <= 1'b1;
                    r_ref[i_cmd.idx]   <= 1'b1;
                    r_dirty[i_cmd.idx] <= i_cmd.wr;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rd.occ   = r_occ[i_rd_idx];
    assign o_rd.ref_b = r_ref[i_rd_idx];
    assign o_rd.dirty = r_dirty[i_rd_idx];

endmodule

`default_nettype wire

@@ rtl/enhanced_clock_frame_replacement.sv @@
`default_nettype none
// Access, release and unused kinds: accepted when idle, result strobed the next cycle,
// one transaction per cycle while not busy. A fault holds busy through a free scan and,
// if no frame is free, a clock sweep of up to four laps over the active frames, one frame
// examined per cycle through the shared frame-table read port; result strobed the cycle after the pick.
// The receiver cannot stall; results are never held.
// Synchronous active-low reset: all frames free, ref/dirty clear, hand 0, frame_count 64.

module enhanced_clock_frame_replacement (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ecfr_pkg::t_req                i_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [ecfr_pkg::COUNT_W-1:0]  i_cfg_data,
    output logic                               o_result_valid,
    output ecfr_pkg::t_result                  o_result
);

    localparam int FW = ecfr_pkg::FRAME_W;
    localparam int CW = ecfr_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_CLOCK = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [FW-1:0]     r_pos, n_pos;
    logic [FW-1:0]     r_hand, n_hand;
    logic [FW-1:0]     r_start, n_start;
    logic [1:0]        r_pass, n_pass;
    logic              r_wr, n_wr;
    logic [CW-1:0]     r_frame_count;
    logic              r_done, n_done;
    ecfr_pkg::t_result r_out, n_out;

    ecfr_pkg::t_tbl_cmd tbl_cmd;
    ecfr_pkg::t_tbl_rd  tbl_rd;
    logic [FW-1:0]      rd_idx;

    logic [CW-1:0] act_n;
    logic [FW-1:0] hand_next;
    logic [FW-1:0] hand_wrap;
    logic          cls_match;

    ecfr_frame_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (tbl_cmd),
        .i_rd_idx (rd_idx),
        .o_rd     (tbl_rd)
    );

    // active frame count: 0 reads as 1, capped at the table depth
    always_comb begin
        if (r_frame_count == '0) begin
            act_n = CW'(1);
        end else if (r_frame_count > CW'(ecfr_pkg::NUM_FRAMES)) begin
            act_n = CW'(ecfr_pkg::NUM_FRAMES);
        end else begin
            act_n = r_frame_count;
        end
    end

    assign rd_idx    = (r_state == ST_CLOCK) ? r_hand : r_pos;
    assign hand_next = ({1'b0, r_hand} + CW'(1) == act_n) ? '0 : r_hand + FW'(1);
    assign hand_wrap = ({1'b0, r_hand} >= act_n) ? '0 : r_hand;
    assign cls_match = (tbl_rd.dirty == r_pass[0]);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_hand  = r_hand;
        n_start = r_start;
        n_pass  = r_pass;
        n_wr    = r_wr;
        n_done  = 1'b0;
        n_out   = '0;
        tbl_cmd = '{op: ecfr_pkg::OP_NONE, idx: '0, wr: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_done = 1'b1;
                    case (i_req.kind)
                        ecfr_pkg::KIND_ACCESS: begin
                            if ({1'b0, i_req.frame_index} < act_n) begin
                                tbl_cmd = '{op: ecfr_pkg::OP_ACCESS,
                                            idx: i_req.frame_index,
                                            wr: i_req.is_write};
                                n_out.found = 1'b1;
                            end
                        end
                        ecfr_pkg::KIND_RELEASE: begin
                            if ({1'b0, i_req.frame_index} < act_n) begin
                                tbl_cmd = '{op: ecfr_pkg::OP_RELEASE,
                                            idx: i_req.frame_index,
                                            wr: 1'b0};
                                n_out.found = 1'b1;
                            end
                        end
                        ecfr_pkg::KIND_FAULT: begin
                            n_done  = 1'b0;
                            n_state = ST_FREE;
                            n_pos   = '0;
                            n_wr    = i_req.is_write;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FREE: begin
                if (!tbl_rd.occ) begin
                    tbl_cmd = '{op: ecfr_pkg::OP_TAKE, idx: r_pos, wr: r_wr};
                    n_out.victim_frame = r_pos;
                    n_out.was_free     = 1'b1;
                    n_out.found        = 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if ({1'b0, r_pos} + CW'(1) == act_n) begin
                    n_state = ST_CLOCK;
                    n_pass  = '0;
                    n_hand  = hand_wrap;
                    n_start = hand_wrap;
                end else begin
                    n_pos = r_pos + FW'(1);
                end
            end
            ST_CLOCK: begin
                if (cls_match && !tbl_rd.ref_b) begin
                    tbl_cmd = '{op: ecfr_pkg::OP_TAKE, idx: r_hand, wr: r_wr};
                    n_out.victim_frame    = r_hand;
                    n_out.needs_writeback = tbl_rd.dirty;
                    n_out.found           = 1'b1;
                    n_done  = 1'b1;
                    n_hand  = hand_next;
                    n_state = ST_IDLE;
                end else begin
                    if (cls_match) begin
                        tbl_cmd = '{op: ecfr_pkg::OP_CLR_REF, idx: r_hand, wr: 1'b0};
                    end
                    n_hand = hand_next;
                    // full lap done: next class, or give up after the fourth lap
                    if (hand_next == r_start) begin
                        if (r_pass == 2'd3) begin
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_pass = r_pass + 2'd1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_hand        <= '0;
            r_frame_count <= CW'(ecfr_pkg::NUM_FRAMES);
            r_done        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hand  <= n_hand;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_start <= n_start;
        r_pass  <= n_pass;
        r_wr    <= n_wr;
        r_out   <= n_out;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_done;
    assign o_result       = r_out;

    a_free_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.was_free) |-> !o_result.needs_writeback)
        else $error("free take reported writeback");

    a_clock_pick_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.found && !o_result.was_free
         && o_result.victim_frame == $past(r_hand))
        |-> ($past(r_state) == ST_CLOCK || $past(r_state) == ST_IDLE))
        else $error("clock victim from unexpected state");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start && i_req.kind == ecfr_pkg::KIND_FAULT)
        |=> (r_state == ST_FREE && r_pos == '0 && !o_result_valid))
        else $error("fault did not start free scan");

    a_hand_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOCK) |-> ({1'b0, r_hand} < act_n))
        else $error("clock hand beyond active frames");

endmodule

`default_nettype wire
